FILE: src/dsos_pkg.sv
// Shared constants, codes and types of the disk seek order scheduler.
`default_nettype none

package dsos_pkg;

  // Sizing of the request stores and fields.
  localparam int MAX_REQUESTS = 32;
  localparam int TRACK_W      = 16;
  localparam int DIST_W       = 16;
  localparam int TOTAL_W      = 22;
  localparam int TOTAL_MAX    = (1 << TOTAL_W) - 1;
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int MODE_W       = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int OUT_RAW_W    = TRACK_W + DIST_W + TOTAL_W;
  localparam int OUT_DATA_W   = ((OUT_RAW_W + 7) / 8) * 8;

  // Scheduling modes.
  localparam logic [MODE_W-1:0] MODE_FCFS  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CSCAN = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCHED_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_TRACK  = 2'd2;

  // One position handed from the sequencer to the seek unit.
  typedef struct packed {
    logic               vld;
    logic               first;
    logic               last;
    logic               dropped;
    logic [TRACK_W-1:0] pos;
  } emit_t;

endpackage

`default_nettype wire

FILE: src/dsos_seek_unit.sv
// Seek distance and running total unit with the result output register.
`default_nettype none

module dsos_seek_unit (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire dsos_pkg::emit_t              emit,
  output logic                              emit_rdy,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // out_tdata fields from bit 0: position[15:0], step_distance[31:16],
  // seek_total[53:32], zero fill[55:54].
  output logic [dsos_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  // out_tuser: dropped.
  output logic                              out_tuser
);
  import dsos_pkg::*;

  logic               out_valid_r;
  logic [TRACK_W-1:0] pos_r;
  logic [DIST_W-1:0]  dist_r;
  logic [TOTAL_W-1:0] total_r;
  logic               last_r;
  logic               drop_r;

  logic [TRACK_W-1:0] dist_raw;
  logic [DIST_W-1:0]  dist_nxt;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total_nxt;
  logic               slot_free;
  logic               take;

  // The slot frees when empty or when its beat leaves this cycle.
  assign slot_free = !out_valid_r || out_tready;
  assign emit_rdy  = slot_free;
  assign take      = emit.vld && slot_free;

  // Absolute step from the previous position and saturating running total.
  always_comb begin
    dist_raw = (emit.pos >= pos_r) ? (emit.pos - pos_r) : (pos_r - emit.pos);
    dist_nxt = emit.first ? '0 : DIST_W'(dist_raw);
    sum      = {1'b0, total_r} + (TOTAL_W + 1)'(dist_nxt);
    if (emit.first) begin
      total_nxt = '0;
    end else if (sum > (TOTAL_W + 1)'(TOTAL_MAX)) begin
      total_nxt = TOTAL_W'(TOTAL_MAX);
    end else begin
      total_nxt = sum[TOTAL_W-1:0];
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= emit.vld;
    end
  end

  // Result payload; position and total also serve as the running state.
  always_ff @(posedge clk) begin
    if (take) begin
      pos_r   <= emit.pos;
      dist_r  <= dist_nxt;
      total_r <= total_nxt;
      last_r  <= emit.last;
      drop_r  <= emit.dropped;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({total_r, dist_r, pos_r});
  assign out_tlast  = last_r;
  assign out_tuser  = drop_r;

endmodule

`default_nettype wire

FILE: src/dsos_ctrl.sv
// Request stores, insertion sort sequencer and service order sequencer.
`default_nettype none

module dsos_ctrl (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [dsos_pkg::TRACK_W-1:0]     in_track,
  input  wire                              in_last,
  input  wire  [dsos_pkg::MODE_W-1:0]      sched_mode,
  input  wire  [dsos_pkg::TRACK_W-1:0]     head_start,
  input  wire  [dsos_pkg::TRACK_W-1:0]     top_track,
  output dsos_pkg::emit_t                  emit,
  input  wire                              emit_rdy
);
  import dsos_pkg::*;

  typedef enum logic [6:0] {
    S_LOAD = 7'b0000001,
    S_SRD  = 7'b0000010,
    S_SLD  = 7'b0000100,
    S_SCHK = 7'b0001000,
    S_SCMP = 7'b0010000,
    S_ERD  = 7'b0100000,
    S_EOUT = 7'b1000000
  } state_t;

  typedef enum logic [6:0] {
    SEG_HEAD = 7'b0000001,
    SEG_UP   = 7'b0000010,
    SEG_TOP  = 7'b0000100,
    SEG_DOWN = 7'b0001000,
    SEG_ZERO = 7'b0010000,
    SEG_LOW  = 7'b0100000,
    SEG_FCFS = 7'b1000000
  } seg_t;

  state_t             state_r, state_nxt;
  seg_t               seg_r, seg_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   split_r, split_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [TRACK_W-1:0] v_r, v_nxt;

  logic [TRACK_W-1:0] arr_mem [MAX_REQUESTS];
  logic [TRACK_W-1:0] srt_mem [MAX_REQUESTS];
  logic [TRACK_W-1:0] arr_q;
  logic [TRACK_W-1:0] srt_q;

  logic               arr_we;
  logic               arr_re;
  logic [IDX_W-1:0]   arr_raddr;
  logic               srt_we;
  logic [IDX_W-1:0]   srt_waddr;
  logic [TRACK_W-1:0] srt_wdata;
  logic               srt_re;
  logic [IDX_W-1:0]   srt_raddr;

  logic [TRACK_W-1:0] trk_clamp;
  logic               sorted_mode;
  logic               cscan;
  logic [CNT_W-1:0]   i_inc;
  logic [CNT_W-1:0]   k_inc;
  logic [CNT_W-1:0]   j_dec;
  logic [CNT_W-1:0]   k_dec;
  logic               is_last;

  assign trk_clamp   = (in_track > top_track) ? top_track : in_track;
  assign sorted_mode = (sched_mode == MODE_SCAN) || (sched_mode == MODE_CSCAN);
  assign cscan       = (sched_mode == MODE_CSCAN);
  assign i_inc       = i_r + CNT_W'(1);
  assign k_inc       = k_r + CNT_W'(1);
  assign j_dec       = j_r - CNT_W'(1);
  assign k_dec       = k_r - CNT_W'(1);

  // Read addresses of both stores.
  assign arr_re    = (state_r == S_SRD) || (state_r == S_ERD);
  assign arr_raddr = (state_r == S_SRD) ? i_r[IDX_W-1:0] : k_r[IDX_W-1:0];
  assign srt_re    = (state_r == S_SCHK) || (state_r == S_ERD);
  assign srt_raddr = (state_r == S_SCHK) ? j_dec[IDX_W-1:0] : k_r[IDX_W-1:0];

  // Final position of the sequence, by segment.
  always_comb begin
    unique case (seg_r) inside
      SEG_TOP:  is_last = !cscan && (split_r == '0);
      SEG_ZERO: is_last = (split_r == '0);
      SEG_DOWN: is_last = (k_r == '0);
      SEG_LOW:  is_last = (k_inc == split_r);
      SEG_FCFS: is_last = (k_inc == cnt_r);
      default:  is_last = 1'b0;
    endcase
  end

  // Position handed to the seek unit.
  always_comb begin
    emit.vld     = (state_r == S_EOUT);
    emit.first   = (seg_r == SEG_HEAD);
    emit.last    = is_last;
    emit.dropped = ovf_r;
    unique case (seg_r) inside
      SEG_HEAD:                  emit.pos = head_start;
      SEG_TOP:                   emit.pos = top_track;
      SEG_ZERO:                  emit.pos = '0;
      SEG_FCFS:                  emit.pos = arr_q;
      SEG_UP, SEG_DOWN, SEG_LOW: emit.pos = srt_q;
      default:                   emit.pos = '0;
    endcase
  end

  // Sequencer: load, insertion sort over the shared comparator for SCAN and C-SCAN, then emit.
  always_comb begin
    state_nxt = state_r;
    seg_nxt   = seg_r;
    cnt_nxt   = cnt_r;
    split_nxt = split_r;
    ovf_nxt   = ovf_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    v_nxt     = v_r;
    arr_we    = 1'b0;
    srt_we    = 1'b0;
    srt_waddr = j_r[IDX_W-1:0];
    srt_wdata = v_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (cnt_r < CNT_W'(MAX_REQUESTS)) begin
            arr_we  = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
            if (trk_clamp < head_start) begin
              split_nxt = split_r + CNT_W'(1);
            end
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            i_nxt   = '0;
            seg_nxt = SEG_HEAD;
            state_nxt = sorted_mode ? S_SRD : S_ERD;
          end
        end
      end
      S_SRD: begin
        state_nxt = S_SLD;
      end
      S_SLD: begin
        v_nxt     = arr_q;
        j_nxt     = i_r;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (j_r == '0) begin
          srt_we = 1'b1;
          i_nxt  = i_inc;
          state_nxt = (i_inc == cnt_r) ? S_ERD : S_SRD;
        end else begin
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        srt_we = 1'b1;
        if (srt_q > v_r) begin
          // Shift the larger entry up one place and keep walking down.
          srt_wdata = srt_q;
          j_nxt     = j_dec;
          state_nxt = S_SCHK;
        end else begin
          i_nxt = i_inc;
          state_nxt = (i_inc == cnt_r) ? S_ERD : S_SRD;
        end
      end
      S_ERD: begin
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        if (emit_rdy) begin
          if (is_last) begin
            cnt_nxt   = '0;
            split_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_ERD;
            unique case (seg_r) inside
              SEG_HEAD: begin
                if (!sorted_mode) begin
                  seg_nxt = SEG_FCFS;
                  k_nxt   = '0;
                end else if (split_r < cnt_r) begin
                  seg_nxt = SEG_UP;
                  k_nxt   = split_r;
                end else begin
                  seg_nxt = SEG_TOP;
                end
              end
              SEG_UP: begin
                if (k_inc < cnt_r) begin
                  k_nxt = k_inc;
                end else begin
                  seg_nxt = SEG_TOP;
                end
              end
              SEG_TOP: begin
                if (cscan) begin
                  seg_nxt = SEG_ZERO;
                end else begin
                  seg_nxt = SEG_DOWN;
                  k_nxt   = split_r - CNT_W'(1);
                end
              end
              SEG_DOWN: k_nxt = k_dec;
              SEG_ZERO: begin
                seg_nxt = SEG_LOW;
                k_nxt   = '0;
              end
              SEG_LOW, SEG_FCFS: k_nxt = k_inc;
              default: seg_nxt = SEG_HEAD;
            endcase
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      seg_r   <= SEG_HEAD;
      cnt_r   <= '0;
      split_r <= '0;
      ovf_r   <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      seg_r   <= seg_nxt;
      cnt_r   <= cnt_nxt;
      split_r <= split_nxt;
      ovf_r   <= ovf_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  // Pending value of the insertion in progress.
  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  // Arrival store: written at load, read with a registered port.
  always_ff @(posedge clk) begin
    if (arr_we) begin
      arr_mem[cnt_r[IDX_W-1:0]] <= trk_clamp;
    end
    if (arr_re) begin
      arr_q <= arr_mem[arr_raddr];
    end
  end

  // Sorted store: written during the sort, read with a registered port.
  always_ff @(posedge clk) begin
    if (srt_we) begin
      srt_mem[srt_waddr] <= srt_wdata;
    end
    if (srt_re) begin
      srt_q <= srt_mem[srt_raddr];
    end
  end

  // The count of requests below the head never exceeds the stored count.
  a_split_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    split_r <= cnt_r)
    else $error("split count above request count");

  // The insertion point stays within the part already sorted.
  a_j_le_i: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCMP) |-> (j_r <= i_r) && (i_r < cnt_r))
    else $error("insertion index out of range");

  // Delivering the final position empties the batch.
  a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.vld && emit.last && emit_rdy) |=> (cnt_r == '0) && !ovf_r && in_tready)
    else $error("batch not cleared after its final position");

endmodule

`default_nettype wire

FILE: src/disk_seek_order_scheduler.sv
// Top level of the disk seek order scheduler: configuration registers and wiring.
//
// Requests load at one per cycle until a beat with in_tlast; tracks above
// top_track are clamped, and requests beyond 32 are dropped and flagged on
// out_tuser. For SCAN and C-SCAN the batch is then insertion-sorted by one
// shared comparator into a sorted store with its own read and write ports:
// each request is read from the arrival store, walked down past every larger
// sorted entry, each shifted up one place, and written in. The service order
// then leaves one result at a time from the registered store reads, starting
// with the head position and with out_tlast on the final one. in_tready stays
// low from the last request until the final result enters the output register.
// Configuration must be written only while idle; the block does not enforce it.
`default_nettype none

module disk_seek_order_scheduler (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  // in_tdata fields from bit 0: track[15:0].
  input  wire  [dsos_pkg::TRACK_W-1:0]          in_tdata,
  input  wire                                   in_tlast,
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  // out_tdata fields from bit 0: position[15:0], step_distance[31:16],
  // seek_total[53:32], zero fill[55:54].
  output logic [dsos_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                  out_tlast,
  // out_tuser: dropped.
  output logic                                  out_tuser,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [dsos_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [dsos_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import dsos_pkg::*;

  logic [MODE_W-1:0]  sched_mode_r;
  logic [TRACK_W-1:0] head_start_r;
  logic [TRACK_W-1:0] top_track_r;
  emit_t              emit;
  logic               emit_rdy;

  assign cfg_ready = 1'b1;

  // Configuration registers; writes to unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sched_mode_r <= MODE_FCFS;
      head_start_r <= '0;
      top_track_r  <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SCHED_MODE: sched_mode_r <= cfg_data[MODE_W-1:0];
        REG_HEAD_START: head_start_r <= cfg_data[TRACK_W-1:0];
        REG_TOP_TRACK:  top_track_r  <= cfg_data[TRACK_W-1:0];
        default: ;
      endcase
    end
  end

  dsos_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_track   (in_tdata),
    .in_last    (in_tlast),
    .sched_mode (sched_mode_r),
    .head_start (head_start_r),
    .top_track  (top_track_r),
    .emit       (emit),
    .emit_rdy   (emit_rdy)
  );

  dsos_seek_unit u_seek (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit       (emit),
    .emit_rdy   (emit_rdy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
